FILE: hw/rtl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg: shared types and codes of the indexed min-heap
// Action and status codes, controller states, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int KEY_W = 10;
	localparam int PRI_PORT_W = 32;

	typedef enum logic [2:0] {
		ACT_PUSH = 3'd0,
		ACT_POP  = 3'd1,
		ACT_DEC  = 3'd2,
		ACT_INC  = 3'd3,
		ACT_PEEK = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_RANGE    = 3'd1,
		ST_ABSENT   = 3'd2,
		ST_PRESENT  = 3'd3,
		ST_FULL     = 3'd4,
		ST_EMPTY    = 3'd5,
		ST_NOCHANGE = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_PM, S_HP, S_LAST, S_UP, S_UPC, S_DN, S_DNL, S_DNR, S_DONE
	} state_t;

	// heap read address source
	typedef enum logic [2:0] {
		HA_LOOKUP, HA_LAST, HA_PARENT, HA_LEFT, HA_RIGHT
	} haddr_t;

	// entry moved into the hole at the current index
	typedef enum logic [1:0] {
		MV_NONE, MV_PARENT, MV_LEFT, MV_RIGHT
	} mv_t;

	typedef struct packed {
		logic   clr_wr;
		logic   ld_req;
		logic   pm_rd;
		logic   ld_pos;
		logic   hp_rd;
		haddr_t haddr;
		logic   ld_res;
		logic   set_push;
		logic   set_upd;
		logic   cnt_dec;
		logic   ld_cur_rd;
		logic   ld_left;
		mv_t    mv;
		logic   wr_cur;
		logic   out_ld;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    clr_last;
		logic    chk_ok;
		logic    last_one;
		logic    is_root;
		logic    up_swap;
		logic    l_exists;
		logic    r_exists;
		mv_t     dn_mv;
		logic    out_busy;
	} stat_t;

endpackage

FILE: hw/rtl/imh_ram.sv
// ----------------------------------------------------------------------------
// imh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/imh_ctrl.sv
// ----------------------------------------------------------------------------
// imh_ctrl: request sequencer of the indexed min-heap
// Walks each request through lookup, check and the sift loop.
// ----------------------------------------------------------------------------
module imh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  imh_pkg::stat_t st,
	output imh_pkg::cmd_t  cmd
);

	imh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imh_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.haddr = imh_pkg::HA_LOOKUP;
		cmd.mv   = imh_pkg::MV_NONE;
		in_stall = (state_q != imh_pkg::S_IDLE);
		unique case (state_q)
			// walk the position map once after reset
			imh_pkg::S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = imh_pkg::S_IDLE;
				end
			end
			imh_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.ld_req = 1'b1;
					cmd.pm_rd  = 1'b1;
					state_d    = imh_pkg::S_PM;
				end
			end
			imh_pkg::S_PM: begin
				cmd.ld_pos = 1'b1;
				cmd.hp_rd  = 1'b1;
				cmd.haddr  = imh_pkg::HA_LOOKUP;
				state_d    = imh_pkg::S_HP;
			end
			imh_pkg::S_HP: begin
				cmd.ld_res = 1'b1;
				state_d    = imh_pkg::S_DONE;
				if (st.chk_ok) begin
					case (st.act)
						imh_pkg::ACT_POP: begin
							cmd.cnt_dec = 1'b1;
							if (!st.last_one) begin
								cmd.hp_rd = 1'b1;
								cmd.haddr = imh_pkg::HA_LAST;
								state_d   = imh_pkg::S_LAST;
							end
						end
						imh_pkg::ACT_PUSH: begin
							cmd.set_push = 1'b1;
							state_d      = imh_pkg::S_UP;
						end
						imh_pkg::ACT_DEC: begin
							cmd.set_upd = 1'b1;
							state_d     = imh_pkg::S_UP;
						end
						imh_pkg::ACT_INC: begin
							cmd.set_upd = 1'b1;
							state_d     = imh_pkg::S_DN;
						end
						default: state_d = imh_pkg::S_DONE;
					endcase
				end
			end
			imh_pkg::S_LAST: begin
				cmd.ld_cur_rd = 1'b1;
				state_d       = imh_pkg::S_DN;
			end
			imh_pkg::S_UP: begin
				if (st.is_root) begin
					cmd.wr_cur = 1'b1;
					state_d    = imh_pkg::S_DONE;
				end else begin
					cmd.hp_rd = 1'b1;
					cmd.haddr = imh_pkg::HA_PARENT;
					state_d   = imh_pkg::S_UPC;
				end
			end
			imh_pkg::S_UPC: begin
				if (st.up_swap) begin
					cmd.mv  = imh_pkg::MV_PARENT;
					state_d = imh_pkg::S_UP;
				end else begin
					cmd.wr_cur = 1'b1;
					state_d    = imh_pkg::S_DONE;
				end
			end
			imh_pkg::S_DN: begin
				if (!st.l_exists) begin
					cmd.wr_cur = 1'b1;
					state_d    = imh_pkg::S_DONE;
				end else begin
					cmd.hp_rd = 1'b1;
					cmd.haddr = imh_pkg::HA_LEFT;
					state_d   = imh_pkg::S_DNL;
				end
			end
			imh_pkg::S_DNL: begin
				cmd.ld_left = 1'b1;
				if (st.r_exists) begin
					cmd.hp_rd = 1'b1;
					cmd.haddr = imh_pkg::HA_RIGHT;
				end
				state_d = imh_pkg::S_DNR;
			end
			imh_pkg::S_DNR: begin
				if (st.dn_mv == imh_pkg::MV_NONE) begin
					cmd.wr_cur = 1'b1;
					state_d    = imh_pkg::S_DONE;
				end else begin
					cmd.mv  = st.dn_mv;
					state_d = imh_pkg::S_DN;
				end
			end
			imh_pkg::S_DONE: begin
				if (!st.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = imh_pkg::S_IDLE;
				end
			end
			default: state_d = imh_pkg::S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/imh_dp.sv
// ----------------------------------------------------------------------------
// imh_dp: datapath of the indexed min-heap
// Heap and position memories, the moving entry, counters and result registers.
// ----------------------------------------------------------------------------
module imh_dp #(
	parameter int MAX_KEYS = 1024,
	parameter int PRIORITY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  imh_pkg::cmd_t                 cmd,
	output imh_pkg::stat_t                st,
	input  logic [2:0]                    action,
	input  logic [imh_pkg::KEY_W-1:0]     item_key,
	input  logic [imh_pkg::PRI_PORT_W-1:0] priority_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [imh_pkg::KEY_W-1:0]     result_key,
	output logic [imh_pkg::PRI_PORT_W-1:0] result_priority,
	output logic                          moved,
	output logic [2:0]                    status
);

	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W = IDX_W + 1;
	localparam int CH_W  = IDX_W + 2;
	localparam int KW    = imh_pkg::KEY_W;
	localparam int HW    = PRIORITY_BITS + KW;

	logic [2:0]               act_q;
	logic [KW-1:0]            key_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [IDX_W-1:0]         pos_q, i_q, start_q;
	logic [IDX_W-1:0]         clr_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [HW-1:0]            cur_q, left_q;
	logic [KW-1:0]            res_key_q;
	logic [PRIORITY_BITS-1:0] res_pri_q;
	logic [2:0]               res_st_q;
	logic                     moved_en_q;
	logic                     out_valid_q, out_moved_q;
	logic [KW-1:0]            out_key_q;
	logic [PRIORITY_BITS-1:0] out_pri_q;
	logic [2:0]               out_st_q;

	logic [IDX_W-1:0]         pm_rdata, pm_raddr, pm_waddr, hp_raddr;
	logic                     pm_we;
	logic [IDX_W-1:0]         pm_wa, pm_wd;
	logic [HW-1:0]            hp_rdata, hp_wdata, mv_src;
	logic                     wr_any;
	logic [31:0]              key_in_ext, key_q_ext, wkey_ext;
	logic [63:0]              pri_in_ext, out_pri_ext;
	logic [CNT_W-1:0]         cnt_m1;
	logic [IDX_W-1:0]         par_idx;
	logic [CH_W-1:0]          l_idx, r_idx, cnt_ext;
	logic                     in_range, present, full;
	logic [PRIORITY_BITS-1:0] rd_pri, cur_pri, left_pri;
	logic                     lok, rok;
	imh_pkg::status_t         chk_st;
	logic [IDX_W-1:0]         mv_idx;

	assign key_in_ext = 32'(item_key);
	assign pri_in_ext = 64'(priority_req);
	assign key_q_ext  = 32'(key_q);
	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign par_idx    = (i_q - IDX_W'(1)) >> 1;
	assign l_idx      = {1'b0, i_q, 1'b1};
	assign r_idx      = {1'b0, i_q, 1'b0} + CH_W'(2);
	assign cnt_ext    = {1'b0, cnt_q};
	assign rd_pri     = hp_rdata[HW-1:KW];
	assign cur_pri    = cur_q[HW-1:KW];
	assign left_pri   = left_q[HW-1:KW];

	// lookup checks; hp_rdata holds the entry at the mapped slot
	assign in_range = key_q_ext < 32'(MAX_KEYS);
	assign present  = in_range && ({1'b0, pos_q} < cnt_q) && (hp_rdata[KW-1:0] == key_q);
	assign full     = (cnt_q == CNT_W'(MAX_KEYS));

	always_comb begin
		case (act_q)
			imh_pkg::ACT_PUSH:
				chk_st = !in_range ? imh_pkg::ST_RANGE :
					present ? imh_pkg::ST_PRESENT :
					full ? imh_pkg::ST_FULL : imh_pkg::ST_OK;
			imh_pkg::ACT_POP:
				chk_st = (cnt_q == '0) ? imh_pkg::ST_EMPTY : imh_pkg::ST_OK;
			imh_pkg::ACT_DEC:
				chk_st = !in_range ? imh_pkg::ST_RANGE :
					!present ? imh_pkg::ST_ABSENT :
					!(pri_q < rd_pri) ? imh_pkg::ST_NOCHANGE : imh_pkg::ST_OK;
			imh_pkg::ACT_INC:
				chk_st = !in_range ? imh_pkg::ST_RANGE :
					!present ? imh_pkg::ST_ABSENT :
					!(pri_q > rd_pri) ? imh_pkg::ST_NOCHANGE : imh_pkg::ST_OK;
			imh_pkg::ACT_PEEK:
				chk_st = !in_range ? imh_pkg::ST_RANGE :
					!present ? imh_pkg::ST_ABSENT : imh_pkg::ST_OK;
			default: chk_st = imh_pkg::ST_NOCHANGE;
		endcase
	end

	assign lok = left_pri <= cur_pri;
	assign rok = (r_idx < cnt_ext) && (rd_pri <= cur_pri);

	always_comb begin
		st.act      = imh_pkg::action_t'(act_q);
		st.clr_last = (clr_q == IDX_W'(MAX_KEYS - 1));
		st.chk_ok   = (chk_st == imh_pkg::ST_OK);
		st.last_one = (cnt_q == CNT_W'(1));
		st.is_root  = (i_q == '0);
		st.up_swap  = rd_pri >= cur_pri;
		st.l_exists = l_idx < cnt_ext;
		st.r_exists = r_idx < cnt_ext;
		st.out_busy = out_valid_q && out_stall;
		if (lok && rok) begin
			st.dn_mv = (rd_pri <= left_pri) ? imh_pkg::MV_RIGHT : imh_pkg::MV_LEFT;
		end else if (lok) begin
			st.dn_mv = imh_pkg::MV_LEFT;
		end else if (rok) begin
			st.dn_mv = imh_pkg::MV_RIGHT;
		end else begin
			st.dn_mv = imh_pkg::MV_NONE;
		end
	end

	always_comb begin
		case (cmd.haddr)
			imh_pkg::HA_LOOKUP:
				hp_raddr = (act_q == imh_pkg::ACT_POP) ? '0 : pm_rdata;
			imh_pkg::HA_LAST:   hp_raddr = cnt_m1[IDX_W-1:0];
			imh_pkg::HA_PARENT: hp_raddr = par_idx;
			imh_pkg::HA_LEFT:   hp_raddr = l_idx[IDX_W-1:0];
			imh_pkg::HA_RIGHT:  hp_raddr = r_idx[IDX_W-1:0];
			default:            hp_raddr = '0;
		endcase
	end

	always_comb begin
		case (cmd.mv)
			imh_pkg::MV_PARENT: begin
				mv_src = hp_rdata;
				mv_idx = par_idx;
			end
			imh_pkg::MV_LEFT: begin
				mv_src = left_q;
				mv_idx = l_idx[IDX_W-1:0];
			end
			imh_pkg::MV_RIGHT: begin
				mv_src = hp_rdata;
				mv_idx = r_idx[IDX_W-1:0];
			end
			default: begin
				mv_src = cur_q;
				mv_idx = i_q;
			end
		endcase
	end

	assign wr_any   = cmd.wr_cur || (cmd.mv != imh_pkg::MV_NONE);
	assign hp_wdata = cmd.wr_cur ? cur_q : mv_src;
	assign wkey_ext = 32'(hp_wdata[KW-1:0]);
	assign pm_waddr = wkey_ext[IDX_W-1:0];
	assign pm_raddr = key_in_ext[IDX_W-1:0];

	// clearing pass after reset gives every position entry a defined slot
	assign pm_we = wr_any || cmd.clr_wr;
	assign pm_wa = cmd.clr_wr ? clr_q : pm_waddr;
	assign pm_wd = cmd.clr_wr ? '0 : i_q;

	imh_ram #(.WIDTH(HW), .DEPTH(MAX_KEYS)) u_heap (
		.clk   (clk),
		.we    (wr_any),
		.waddr (i_q),
		.wdata (hp_wdata),
		.re    (cmd.hp_rd),
		.raddr (hp_raddr),
		.rdata (hp_rdata)
	);

	imh_ram #(.WIDTH(IDX_W), .DEPTH(MAX_KEYS)) u_posmap (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_wa),
		.wdata (pm_wd),
		.re    (cmd.pm_rd),
		.raddr (pm_raddr),
		.rdata (pm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.set_push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			act_q <= action;
			key_q <= item_key;
			pri_q <= pri_in_ext[PRIORITY_BITS-1:0];
		end
		if (cmd.ld_pos) begin
			pos_q <= pm_rdata;
		end
		if (cmd.ld_res) begin
			res_st_q   <= chk_st;
			moved_en_q <= (chk_st == imh_pkg::ST_OK) &&
				((act_q == imh_pkg::ACT_DEC) || (act_q == imh_pkg::ACT_INC));
			if (act_q == imh_pkg::ACT_POP) begin
				res_key_q <= (chk_st == imh_pkg::ST_OK) ? hp_rdata[KW-1:0] : '0;
				res_pri_q <= (chk_st == imh_pkg::ST_OK) ? rd_pri : '0;
			end else begin
				res_key_q <= key_q;
				res_pri_q <= ((act_q == imh_pkg::ACT_PEEK) && (chk_st == imh_pkg::ST_OK)) ?
					rd_pri : '0;
			end
		end
		if (cmd.set_push) begin
			cur_q   <= {pri_q, key_q};
			i_q     <= cnt_q[IDX_W-1:0];
			start_q <= cnt_q[IDX_W-1:0];
		end else if (cmd.set_upd) begin
			cur_q   <= {pri_q, key_q};
			i_q     <= pos_q;
			start_q <= pos_q;
		end else if (cmd.ld_cur_rd) begin
			cur_q   <= hp_rdata;
			i_q     <= '0;
			start_q <= '0;
		end else if (cmd.mv != imh_pkg::MV_NONE) begin
			i_q <= mv_idx;
		end
		if (cmd.ld_left) begin
			left_q <= hp_rdata;
		end
		if (cmd.out_ld) begin
			out_key_q   <= res_key_q;
			out_pri_q   <= res_pri_q;
			out_st_q    <= res_st_q;
			out_moved_q <= moved_en_q && (i_q != start_q);
		end
	end

	assign out_pri_ext     = 64'(out_pri_q);
	assign out_valid       = out_valid_q;
	assign result_key      = out_key_q;
	assign result_priority = out_pri_ext[imh_pkg::PRI_PORT_W-1:0];
	assign moved           = out_moved_q;
	assign status          = out_st_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_KEYS))
		else $error("entry count above capacity");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_push |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("push did not grow the heap by one");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_cur && (cmd.mv != imh_pkg::MV_NONE)))
		else $error("two heap writes in one cycle");
	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.hp_rd && wr_any))
		else $error("heap read and write in one cycle");
`endif

endmodule

FILE: hw/rtl/indexed_min_heap_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_top: addressable binary min-heap of (priority, key) pairs
// Push, pop, decrease, increase and peek requests with one result each.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one result per
// request. After reset it clears the position map with in_stall high. A
// request passes through lookup, check and result load, then the sift: moving
// up reads the parent and compares at each level, moving down reads the left
// and then the right child at each level, and each sift closes with a write
// of the moving entry; pop also fetches the last entry before it sinks. The
// single read port of the heap memory sets these steps. The result may also
// wait on out_stall. A finished result sits in the output register while the
// next request is taken. A key counts as present only when its mapped slot is
// below the entry count and holds that key, so stale position entries left by
// pops are harmless.
module indexed_min_heap_top #(
	parameter int MAX_KEYS = 1024,
	parameter int PRIORITY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [9:0]  item_key,
	input  logic [31:0] priority_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  result_key,
	output logic [31:0] result_priority,
	output logic        moved,
	output logic [2:0]  status
);

	// command and status bundles between sequencer and datapath
	imh_pkg::cmd_t  cmd;
	imh_pkg::stat_t st;

	// sequencer: advance each request through lookup and sift steps
	imh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: hold the heap, position map, count and the result transfer
	imh_dp #(
		.MAX_KEYS      (MAX_KEYS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.action          (action),
		.item_key        (item_key),
		.priority_req    (priority_req),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_key      (result_key),
		.result_priority (result_priority),
		.moved           (moved),
		.status          (status)
	);

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed min-heap
// Drives push, pop, decrease, increase, peek and undefined actions through
// the valid/stall channels, predicts every result with a behavioral heap and
// compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NKEYS = 1024;

	typedef struct {
		logic [9:0]  rkey;
		logic [31:0] rpri;
		logic        mv;
		logic [2:0]  st;
	} heap_result_t;

	// behavioral heap plus the queue of results it predicts
	class heap_scoreboard;
		logic [31:0]  pri_at[NKEYS];
		int           key_at[NKEYS];
		int           slot_of[NKEYS];
		int           count;
		heap_result_t pending[$];
		int           errors;
		int           checked;

		function void clear();
			count = 0;
			errors = 0;
			checked = 0;
			for (int k = 0; k < NKEYS; k++) begin
				slot_of[k] = NKEYS;
			end
		endfunction

		function void exchange(int a, int b);
			logic [31:0] tp;
			int tk;
			tp = pri_at[a]; pri_at[a] = pri_at[b]; pri_at[b] = tp;
			tk = key_at[a]; key_at[a] = key_at[b]; key_at[b] = tk;
			slot_of[key_at[a]] = a;
			slot_of[key_at[b]] = b;
		endfunction

		// ties rise past an equal parent
		function int rise(int i);
			int p;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (pri_at[p] >= pri_at[i]) begin
					exchange(p, i);
					i = p;
				end else break;
			end
			return i;
		endfunction

		// ties sink, the right child wins when children are equal
		function int sink(int i);
			int l, r, nx;
			bit lok, rok;
			forever begin
				l = 2 * i + 1;
				r = 2 * i + 2;
				lok = l < count && pri_at[l] <= pri_at[i];
				rok = r < count && pri_at[r] <= pri_at[i];
				if (lok && rok) nx = (pri_at[r] <= pri_at[l]) ? r : l;
				else if (lok) nx = l;
				else if (rok) nx = r;
				else break;
				exchange(i, nx);
				i = nx;
			end
			return i;
		endfunction

		function bit has_key(int k);
			return slot_of[k] < count;
		endfunction

		function void note_request(logic [2:0] act, logic [9:0] k, logic [31:0] p);
			heap_result_t res;
			int pos, np, last;
			bit present;
			pos = slot_of[k];
			present = pos < count;
			res.rkey = k; res.rpri = '0; res.mv = 1'b0; res.st = imh_pkg::ST_OK;
			case (act)
				imh_pkg::ACT_PUSH: begin
					if (present) res.st = imh_pkg::ST_PRESENT;
					else if (count >= NKEYS) res.st = imh_pkg::ST_FULL;
					else begin
						pri_at[count] = p; key_at[count] = k; slot_of[k] = count;
						count++;
						void'(rise(count - 1));
					end
				end
				imh_pkg::ACT_POP: begin
					if (count == 0) begin
						res.st = imh_pkg::ST_EMPTY;
						res.rkey = '0;
					end else begin
						res.rkey = key_at[0];
						res.rpri = pri_at[0];
						slot_of[key_at[0]] = NKEYS;
						last = count - 1;
						count = last;
						if (last > 0) begin
							pri_at[0] = pri_at[last]; key_at[0] = key_at[last];
							slot_of[key_at[0]] = 0;
							void'(sink(0));
						end
					end
				end
				imh_pkg::ACT_DEC, imh_pkg::ACT_INC: begin
					if (!present) res.st = imh_pkg::ST_ABSENT;
					else if (act == imh_pkg::ACT_DEC ? !(p < pri_at[pos])
						: !(p > pri_at[pos]))
						res.st = imh_pkg::ST_NOCHANGE;
					else begin
						pri_at[pos] = p;
						np = (act == imh_pkg::ACT_DEC) ? rise(pos) : sink(pos);
						res.mv = np != pos;
					end
				end
				imh_pkg::ACT_PEEK: begin
					if (!present) res.st = imh_pkg::ST_ABSENT;
					else res.rpri = pri_at[pos];
				end
				default: res.st = imh_pkg::ST_NOCHANGE;
			endcase
			pending.push_back(res);
		endfunction

		function void check_result(logic [9:0] k, logic [31:0] p, logic m, logic [2:0] s);
			heap_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: key %0d status %0d", k, s);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (k !== e.rkey) begin
				$error("result_key expected %0d got %0d", e.rkey, k); errors++;
			end
			if (p !== e.rpri) begin
				$error("result_priority expected %0h got %0h", e.rpri, p); errors++;
			end
			if (m !== e.mv) begin
				$error("moved expected %0d got %0d", e.mv, m); errors++;
			end
			if (s !== e.st) begin
				$error("status expected %0d got %0d", e.st, s); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  action;
	logic [9:0]  item_key;
	logic [31:0] priority_req;
	logic        out_valid;
	logic        out_stall;
	logic [9:0]  result_key;
	logic [31:0] result_priority;
	logic        moved;
	logic [2:0]  status;

	heap_scoreboard board;
	int  sent;
	int  burst_left;
	bit  rx_calm;

	indexed_min_heap_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .item_key(item_key), .priority_req(priority_req),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_key(result_key), .result_priority(result_priority),
		.moved(moved), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hold off the next request for a random gap between bursts
	task automatic idle_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 12);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// present one request and hold it until the transfer happens
	task automatic send_request(logic [2:0] act, logic [9:0] k, logic [31:0] p);
		idle_gap();
		in_valid <= 1'b1;
		action <= act;
		item_key <= k;
		priority_req <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(act, k, p);
		sent++;
	endtask

	// drop valid and wait for every expected result to arrive
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// priority biased toward small values so ties come up often
	function automatic logic [31:0] pick_pri();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(0, 7));
			3: return 32'($urandom_range(0, 200));
			default: return 32'($urandom);
		endcase
	endfunction

	// mostly keys from a small pool so pushes and lookups meet each other
	function automatic logic [9:0] pick_key();
		if ($urandom_range(0, 9) < 7) return 10'($urandom_range(0, 63));
		return 10'($urandom);
	endfunction

	// receiver stall pattern: calm stretches and busy stretches alternate
	initial begin
		out_stall = 1'b0;
		rx_calm = 1'b1;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) == 0) rx_calm <= ~rx_calm;
			out_stall <= rx_calm ? 1'b0 : ($urandom_range(0, 2) != 0);
		end
	end

	// check each result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(result_key, result_priority, moved, status);
	end

	initial begin
		logic [2:0] a;
		logic [9:0] k;
		int pick;
		board = new();
		board.clear();
		sent = 0;
		burst_left = 0;
		in_valid = 1'b0;
		action = imh_pkg::ACT_PUSH;
		item_key = '0;
		priority_req = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, absent key, extremes, ties, bad actions
		send_request(imh_pkg::ACT_POP, 10'd5, 32'd0);
		send_request(imh_pkg::ACT_PEEK, 10'd0, 32'd0);
		send_request(imh_pkg::ACT_DEC, 10'd1023, 32'd0);
		send_request(imh_pkg::ACT_INC, 10'd3, 32'd9);
		send_request(imh_pkg::ACT_PUSH, 10'd1023, 32'hFFFF_FFFF);
		send_request(imh_pkg::ACT_PUSH, 10'd0, 32'd0);
		send_request(imh_pkg::ACT_PUSH, 10'd0, 32'd7);
		send_request(imh_pkg::ACT_PUSH, 10'd7, 32'd0);
		send_request(imh_pkg::ACT_PUSH, 10'd8, 32'd5);
		send_request(imh_pkg::ACT_PUSH, 10'd9, 32'd5);
		send_request(imh_pkg::ACT_PEEK, 10'd1023, 32'd0);
		send_request(imh_pkg::ACT_DEC, 10'd1023, 32'd1);
		send_request(imh_pkg::ACT_DEC, 10'd8, 32'd5);
		send_request(imh_pkg::ACT_INC, 10'd7, 32'd0);
		send_request(imh_pkg::ACT_INC, 10'd0, 32'hFFFF_FFFF);
		send_request(3'd5, 10'd21, 32'hAAAA_5555);
		send_request(3'd6, 10'd682, 32'h5555_AAAA);
		send_request(3'd7, 10'd341, 32'd1);
		repeat (6) send_request(imh_pkg::ACT_POP, 10'd0, 32'd0);
		drain();

		// random: phases build up, churn, and drain the heap
		for (int n = 0; n < 1400; n++) begin
			pick = $urandom_range(0, 99);
			k = pick_key();
			if (n % 350 < 120) a = (pick < 60) ? imh_pkg::ACT_PUSH
				: (pick < 70) ? imh_pkg::ACT_POP
				: (pick < 80) ? imh_pkg::ACT_DEC
				: (pick < 90) ? imh_pkg::ACT_INC : imh_pkg::ACT_PEEK;
			else if (n % 350 < 280) a = (pick < 30) ? imh_pkg::ACT_PUSH
				: (pick < 50) ? imh_pkg::ACT_POP
				: (pick < 68) ? imh_pkg::ACT_DEC
				: (pick < 86) ? imh_pkg::ACT_INC
				: (pick < 97) ? imh_pkg::ACT_PEEK
				: 3'($urandom_range(5, 7));
			else a = (pick < 80) ? imh_pkg::ACT_POP : imh_pkg::ACT_PEEK;
			send_request(a, k, pick_pri());
			if (n == 700) drain();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("Ran %0d requests of every action, with %0d results compared.",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// slowest run: ~1430 requests, each with its sift, idle gap and long stalls, << 20 ms
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

endmodule
